/* src/sck_pkg.sv */
// Shared types, constants and translation tables for the scancode event queue.
// Used by sck_decode, sck_ring and scancode_to_key_event_fifo; depends on nothing.
package sck_pkg;

  localparam int RING_DEPTH = 128;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  typedef logic [RING_AW-1:0] ring_idx_t;

  // request action codes
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_POLL = 1'b1;

  // set-1 codes
  localparam logic [7:0] PREFIX_BYTE = 8'hE0;
  localparam logic [6:0] CODE_LSHIFT = 7'h2A;
  localparam logic [6:0] CODE_RSHIFT = 7'h36;
  localparam logic [6:0] CODE_CTRL   = 7'h1D;
  localparam logic [6:0] CODE_ALT    = 7'h38;
  localparam logic [6:0] CODE_CAPS   = 7'h3A;

  // modifier bits
  localparam logic [3:0] MOD_SHIFT = 4'h1;
  localparam logic [3:0] MOD_CTRL  = 4'h2;
  localparam logic [3:0] MOD_ALT   = 4'h4;
  localparam logic [3:0] MOD_CAPS  = 4'h8;

  typedef struct packed {
    logic       action;
    logic [7:0] scan_byte;
  } req_t;

  typedef struct packed {
    logic       event_valid;
    logic [6:0] event_scancode;
    logic [6:0] event_char;
    logic [3:0] event_modifiers;
    logic [3:0] live_modifiers;
    logic       dropped;
  } rsp_t;

  // stored event: modifiers in bits 17..14, char in 13..7, code in 6..0
  typedef struct packed {
    logic [3:0] mods;
    logic [6:0] chr;
    logic [6:0] code;
  } entry_t;

  // decoder to ring: what the accepted request asks of the queue
  typedef struct packed {
    logic       push;
    entry_t     entry;
    logic [3:0] live;
  } dec_t;

  // ring to top: outcome of the accepted request
  typedef struct packed {
    logic hit;
    logic dropped;
  } ring_stat_t;

  function automatic ring_idx_t ring_next(input ring_idx_t idx);
    ring_next = (idx == RING_AW'(RING_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [6:0] plain_char(input logic [6:0] code);
    logic [6:0] c;
    case (code)
      7'h01: c = 7'h1B;  7'h02: c = 7'h31;  7'h03: c = 7'h32;  7'h04: c = 7'h33;
      7'h05: c = 7'h34;  7'h06: c = 7'h35;  7'h07: c = 7'h36;  7'h08: c = 7'h37;
      7'h09: c = 7'h38;  7'h0A: c = 7'h39;  7'h0B: c = 7'h30;  7'h0C: c = 7'h2D;
      7'h0D: c = 7'h3D;  7'h0E: c = 7'h08;  7'h0F: c = 7'h09;
      7'h10: c = 7'h71;  7'h11: c = 7'h77;  7'h12: c = 7'h65;  7'h13: c = 7'h72;
      7'h14: c = 7'h74;  7'h15: c = 7'h79;  7'h16: c = 7'h75;  7'h17: c = 7'h69;
      7'h18: c = 7'h6F;  7'h19: c = 7'h70;  7'h1A: c = 7'h5B;  7'h1B: c = 7'h5D;
      7'h1C: c = 7'h0A;  7'h1E: c = 7'h61;  7'h1F: c = 7'h73;
      7'h20: c = 7'h64;  7'h21: c = 7'h66;  7'h22: c = 7'h67;  7'h23: c = 7'h68;
      7'h24: c = 7'h6A;  7'h25: c = 7'h6B;  7'h26: c = 7'h6C;  7'h27: c = 7'h3B;
      7'h28: c = 7'h27;  7'h29: c = 7'h60;  7'h2B: c = 7'h5C;
      7'h2C: c = 7'h7A;  7'h2D: c = 7'h78;  7'h2E: c = 7'h63;  7'h2F: c = 7'h76;
      7'h30: c = 7'h62;  7'h31: c = 7'h6E;  7'h32: c = 7'h6D;  7'h33: c = 7'h2C;
      7'h34: c = 7'h2E;  7'h35: c = 7'h2F;  7'h37: c = 7'h2A;  7'h39: c = 7'h20;
      7'h49: c = 7'h37;  7'h4A: c = 7'h38;  7'h4B: c = 7'h39;  7'h4C: c = 7'h2D;
      7'h4D: c = 7'h34;  7'h4E: c = 7'h35;  7'h4F: c = 7'h36;  7'h50: c = 7'h2B;
      7'h51: c = 7'h31;  7'h52: c = 7'h32;  7'h53: c = 7'h33;  7'h54: c = 7'h30;
      7'h55: c = 7'h2E;
      default: c = 7'h00;
    endcase
    plain_char = c;
  endfunction

  function automatic logic [6:0] shifted_char(input logic [6:0] code);
    logic [6:0] c;
    case (code)
      7'h01: c = 7'h1B;  7'h02: c = 7'h21;  7'h03: c = 7'h40;  7'h04: c = 7'h23;
      7'h05: c = 7'h24;  7'h06: c = 7'h25;  7'h07: c = 7'h5E;  7'h08: c = 7'h26;
      7'h09: c = 7'h2A;  7'h0A: c = 7'h28;  7'h0B: c = 7'h29;  7'h0C: c = 7'h5F;
      7'h0D: c = 7'h2B;  7'h0E: c = 7'h08;  7'h0F: c = 7'h09;
      7'h10: c = 7'h51;  7'h11: c = 7'h57;  7'h12: c = 7'h45;  7'h13: c = 7'h52;
      7'h14: c = 7'h54;  7'h15: c = 7'h59;  7'h16: c = 7'h55;  7'h17: c = 7'h49;
      7'h18: c = 7'h4F;  7'h19: c = 7'h50;  7'h1A: c = 7'h7B;  7'h1B: c = 7'h7D;
      7'h1C: c = 7'h0A;  7'h1E: c = 7'h41;  7'h1F: c = 7'h53;
      7'h20: c = 7'h44;  7'h21: c = 7'h46;  7'h22: c = 7'h47;  7'h23: c = 7'h48;
      7'h24: c = 7'h4A;  7'h25: c = 7'h4B;  7'h26: c = 7'h4C;  7'h27: c = 7'h3A;
      7'h28: c = 7'h22;  7'h29: c = 7'h7E;  7'h2B: c = 7'h7C;
      7'h2C: c = 7'h5A;  7'h2D: c = 7'h58;  7'h2E: c = 7'h43;  7'h2F: c = 7'h56;
      7'h30: c = 7'h42;  7'h31: c = 7'h4E;  7'h32: c = 7'h4D;  7'h33: c = 7'h3C;
      7'h34: c = 7'h3E;  7'h35: c = 7'h3F;  7'h37: c = 7'h2A;  7'h39: c = 7'h20;
      7'h49: c = 7'h37;  7'h4A: c = 7'h38;  7'h4B: c = 7'h39;  7'h4C: c = 7'h2D;
      7'h4D: c = 7'h34;  7'h4E: c = 7'h35;  7'h4F: c = 7'h36;  7'h50: c = 7'h2B;
      7'h51: c = 7'h31;  7'h52: c = 7'h32;  7'h53: c = 7'h33;  7'h54: c = 7'h30;
      7'h55: c = 7'h2E;
      default: c = 7'h00;
    endcase
    shifted_char = c;
  endfunction

  // pick table by shift, then let caps flip the case of letters
  function automatic logic [6:0] translate(input logic [6:0] code, input logic [3:0] mods);
    logic [6:0] c;
    c = ((mods & MOD_SHIFT) != '0) ? shifted_char(code) : plain_char(code);
    if ((mods & MOD_CAPS) != '0) begin
      if (c >= 7'h61 && c <= 7'h7A) begin
        c = c & 7'h5F;
      end else if (c >= 7'h41 && c <= 7'h5A) begin
        c = c | 7'h20;
      end
    end
    translate = c;
  endfunction

endpackage

/* src/scancode_to_key_event_fifo.sv */
// Top level: set-1 scancode to key event translator with an event queue.
// Depends on sck_pkg, sck_decode and sck_ring.
//
//   channel  | valid      | stall      | payload | carries
//   ---------+------------+------------+---------+------------------------------
//   request  | req_valid  | req_stall  | req     | scancode byte or poll
//   response | rsp_valid  | rsp_stall  | rsp     | popped event, live mods, drop
//
// One request per cycle unless stalled; each request gives exactly one response.
// The request edge issues the ring access and fills the middle stage; the ring
// read data then lands in the output register once the output is free.
// Reset (rst, synchronous) clears modifiers, ring pointers and all valid flags;
// ring contents are not cleared and need no clearing pass.
// A stalled response holds; one more request is taken into the middle stage
// while a response waits, then req_stall rises until the output drains.
module scancode_to_key_event_fifo import sck_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic       accept;
  logic       pop;
  dec_t       dec;
  ring_stat_t stat;
  entry_t     rdata;

  // middle stage: waits for the ring read data
  logic       s1_valid;
  logic       s1_hit;
  logic       s1_dropped;
  logic [3:0] s1_live;
  logic       s1_move;

  // advance the middle stage when the output register is empty or being taken
  assign s1_move   = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !s1_move;
  assign accept    = req_valid && !req_stall;
  assign pop       = accept && (req.action == ACT_POLL);

  sck_decode u_decode (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (req),
    .dec    (dec)
  );

  // rdata changes only on a pop, and no request is taken while s1 holds
  sck_ring u_ring (
    .clk   (clk),
    .rst   (rst),
    .push  (dec.push),
    .pop   (pop),
    .wdata (dec.entry),
    .stat  (stat),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hit     <= stat.hit;
      s1_dropped <= stat.dropped;
      s1_live    <= dec.live;
    end
    if (s1_move) begin
      rsp.event_valid     <= s1_hit;
      rsp.event_scancode  <= s1_hit ? rdata.code : '0;
      rsp.event_char      <= s1_hit ? rdata.chr  : '0;
      rsp.event_modifiers <= s1_hit ? rdata.mods : '0;
      rsp.live_modifiers  <= s1_live;
      rsp.dropped         <= s1_dropped;
    end
  end

  // a request can never both pop an event and lose a push
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.event_valid && rsp.dropped))
    else $error("response shows both a popped event and a drop");

  // a blocked middle stage keeps its request
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_move) |=> s1_valid)
    else $error("middle stage lost a request while blocked");

  // a scancode byte never yields a popped event
  assert property (@(posedge clk) disable iff (rst)
    (accept && req.action == ACT_BYTE) |=> !s1_hit)
    else $error("scancode byte produced a pop");

  // stall is only raised while the middle stage is occupied
  assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (s1_valid && rsp_valid))
    else $error("request stalled with room in the pipeline");

endmodule

/* src/sck_decode.sv */
// Scancode decoder: modifier register, prefix and release handling, translation.
// Depends on sck_pkg.
module sck_decode import sck_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  req_t req,
  output dec_t dec
);

  logic [3:0] modifier_bits;
  logic [3:0] modifier_bits_next;
  logic [3:0] mod_mask;
  logic [6:0] code;
  logic       pressed;
  logic       is_byte;
  logic       push;

  assign code    = req.scan_byte[6:0];
  assign pressed = ~req.scan_byte[7];
  assign is_byte = accept && (req.action == ACT_BYTE) && (req.scan_byte != PREFIX_BYTE);

  always_comb begin
    unique case (code) inside
      CODE_LSHIFT, CODE_RSHIFT: mod_mask = MOD_SHIFT;
      CODE_CTRL:                mod_mask = MOD_CTRL;
      CODE_ALT:                 mod_mask = MOD_ALT;
      default:                  mod_mask = '0;
    endcase
  end

  always_comb begin
    modifier_bits_next = modifier_bits;
    push               = 1'b0;
    if (is_byte) begin
      if (mod_mask != '0) begin
        modifier_bits_next = pressed ? (modifier_bits | mod_mask)
                                     : (modifier_bits & ~mod_mask);
      end else if (code == CODE_CAPS) begin
        if (pressed) begin
          modifier_bits_next = modifier_bits ^ MOD_CAPS;
        end
      end else if (pressed) begin
        push = 1'b1;
      end
    end
  end

  assign dec.push       = push;
  assign dec.entry.mods = modifier_bits;
  assign dec.entry.chr  = translate(code, modifier_bits);
  assign dec.entry.code = code;
  assign dec.live       = modifier_bits_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      modifier_bits <= '0;
    end else begin
      modifier_bits <= modifier_bits_next;
    end
  end

endmodule

/* src/sck_ring.sv */
// Event ring: synchronous memory with read and write pointers and a registered read port.
// Depends on sck_pkg.
module sck_ring import sck_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       pop,
  input  entry_t     wdata,
  output ring_stat_t stat,
  output entry_t     rdata
);

  entry_t    mem [RING_DEPTH];
  ring_idx_t write_index;
  ring_idx_t read_index;
  logic      full;
  logic      empty;
  logic      do_push;
  logic      do_pop;

  assign full    = (ring_next(write_index) == read_index);
  assign empty   = (write_index == read_index);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  assign stat.hit     = do_pop;
  assign stat.dropped = push && full;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[write_index] <= wdata;
    end
    if (do_pop) begin
      rdata <= mem[read_index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      read_index  <= '0;
    end else begin
      if (do_push) begin
        write_index <= ring_next(write_index);
      end
      if (do_pop) begin
        read_index <= ring_next(read_index);
      end
    end
  end

endmodule

/* bench/tb_scancode_to_key_event_fifo.sv */
`timescale 1ns / 1ps
// Self-checking bench for the scancode to key event queue: random and directed
// requests, own model of modifiers, translation and event ring.
// Depends on sck_pkg and scancode_to_key_event_fifo.
module tb_scancode_to_key_event_fifo;
  import sck_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before the run is declared hung
  localparam int LONG_HOLD      = 300;   // receiver hold-off that backs up the pipeline
  localparam int DRAIN_CYCLES   = 10;    // settle time after the last response
  localparam int RANDOM_ITEMS   = 1300;
  localparam int KEY_TABLE_LEN  = 88;    // codes at or above this have no character
  localparam logic [7:0] CASE_GAP = 8'd32;

  // Character tables, entry 0 first.
  localparam logic [0:KEY_TABLE_LEN-1][7:0] PLAIN_KEYS = {
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h37, 8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36,
    8'h2B, 8'h31, 8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00
  };
  localparam logic [0:KEY_TABLE_LEN-1][7:0] SHIFT_KEYS = {
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h37, 8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36,
    8'h2B, 8'h31, 8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00
  };

  // A pending request plus a flag that makes the sender wait for all
  // outstanding responses before offering it.
  typedef struct packed {
    logic drain_first;
    req_t item;
  } keystroke_t;

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  req_t req       = '0;
  logic rsp_stall = 1'b0;
  logic req_stall;
  logic rsp_valid;
  rsp_t rsp;

  keystroke_t keystroke_queue[$];
  rsp_t       key_replies[$];     // responses owed by the block, oldest first
  keystroke_t head;
  rsp_t       want;
  bit         drain_next = 1'b0;

  // Model state: live modifiers and the event ring.
  logic [3:0]  mods_now = '0;
  logic [17:0] ring_copy [0:RING_DEPTH-1];
  ring_idx_t   ring_wr = '0;
  ring_idx_t   ring_rd = '0;

  // Handshake bookkeeping, written at the rising edge, read at the falling edge.
  logic req_taken     = 1'b0;
  logic rsp_taken     = 1'b0;
  int   reqs_accepted = 0;
  int   replies_seen  = 0;
  int   errors        = 0;
  int   quiet_cycles  = 0;
  int   send_wait     = 0;
  int   recv_left     = 0;
  bit   send_calm     = 1'b0;
  bit   recv_calm     = 1'b0;

  scancode_to_key_event_fifo u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic ring_idx_t ring_step(input ring_idx_t idx);
    return (idx == ring_idx_t'(RING_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  // Look up the character for a make code; caps flips the case of letters
  // after the table is chosen, so shift plus caps gives lowercase.
  function automatic logic [6:0] key_char(input logic [6:0] code, input logic [3:0] mods);
    logic [7:0] c;
    c = 8'h00;
    if (code < 7'(KEY_TABLE_LEN)) begin
      c = ((mods & MOD_SHIFT) != '0) ? SHIFT_KEYS[code] : PLAIN_KEYS[code];
    end
    if ((mods & MOD_CAPS) != '0) begin
      if (c >= "a" && c <= "z") begin
        c = c - CASE_GAP;
      end else if (c >= "A" && c <= "Z") begin
        c = c + CASE_GAP;
      end
    end
    return c[6:0];
  endfunction

  // Advance the model by one accepted request and return the response it owes.
  function automatic rsp_t decode_key_request(input req_t r);
    rsp_t        o;
    logic [6:0]  code;
    logic [3:0]  mod_bit;
    logic [17:0] slot;
    o = '0;
    code = r.scan_byte[6:0];
    if (r.action == ACT_POLL) begin
      // pop the oldest event; an empty ring leaves everything alone
      if (ring_wr != ring_rd) begin
        slot = ring_copy[ring_rd];
        o.event_valid     = 1'b1;
        o.event_scancode  = slot[6:0];
        o.event_char      = slot[13:7];
        o.event_modifiers = slot[17:14];
        ring_rd = ring_step(ring_rd);
      end
    end else if (r.scan_byte != PREFIX_BYTE) begin
      mod_bit = (code == CODE_LSHIFT || code == CODE_RSHIFT) ? MOD_SHIFT :
                (code == CODE_CTRL) ? MOD_CTRL :
                (code == CODE_ALT)  ? MOD_ALT  : '0;
      if (mod_bit != '0) begin
        mods_now = r.scan_byte[7] ? (mods_now & ~mod_bit) : (mods_now | mod_bit);
      end else if (code == CODE_CAPS) begin
        if (!r.scan_byte[7]) mods_now = mods_now ^ MOD_CAPS;
      end else if (!r.scan_byte[7]) begin
        // the ring keeps one slot free; a press into a full ring is lost
        if (ring_step(ring_wr) == ring_rd) begin
          o.dropped = 1'b1;
        end else begin
          ring_copy[ring_wr] = {mods_now, key_char(code, mods_now), code};
          ring_wr = ring_step(ring_wr);
        end
      end
    end
    o.live_modifiers = mods_now;
    return o;
  endfunction

  task automatic match_field(input string what, input logic [7:0] exp_val,
                             input logic [7:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t ns  %s mismatch: expected %0h, actual %0h", $time, what, exp_val, act_val);
      errors++;
    end
  endtask

  task automatic add_item(input logic act, input logic [7:0] b);
    keystroke_queue.push_back({drain_next, act, b});
    drain_next = 1'b0;
  endtask

  // Random make code, usually one with a table entry; never a modifier or caps.
  function automatic logic [6:0] pick_key();
    logic [6:0] c;
    do begin
      c = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                      : 7'($urandom_range(1, 8'h53));
    end while (c == CODE_LSHIFT || c == CODE_RSHIFT || c == CODE_CTRL ||
               c == CODE_ALT || c == CODE_CAPS);
    return c;
  endfunction

  // Sender: hold a request until it is taken, then idle for the drawn gap
  // and offer the next one. A flagged request waits until nothing is owed.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (send_wait != 0) begin
        req_valid <= 1'b0;
        send_wait <= send_wait - 1;
      end else if (keystroke_queue.size() != 0 &&
                   !(keystroke_queue[0].drain_first && key_replies.size() != 0)) begin
        head = keystroke_queue.pop_front();
        req       <= head.item;
        req_valid <= 1'b1;
        if ($urandom_range(0, 40) == 0) send_calm = !send_calm;
        send_wait <= send_calm ? 0 : $urandom_range(0, 13);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Receiver: draw a stall count per response; twice in the run hold off
  // long enough for the pipeline to back up into the request side.
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_taken) begin
        if ($urandom_range(0, 40) == 0) recv_calm = !recv_calm;
        recv_left = (replies_seen % 700 == 200) ? LONG_HOLD :
                    (recv_calm ? 0 : $urandom_range(0, 13));
      end
      rsp_stall <= (recv_left != 0);
      if (recv_left != 0) recv_left = recv_left - 1;
    end
  end

  // Monitor: check each taken response against the oldest owed one, then
  // run the model on the request taken at this edge.
  always @(posedge clk) begin
    if (rst) begin
      req_taken <= 1'b0;
      rsp_taken <= 1'b0;
    end else begin
      req_taken <= req_valid && !req_stall;
      rsp_taken <= rsp_valid && !rsp_stall;
      if (rsp_valid && !rsp_stall) begin
        replies_seen <= replies_seen + 1;
        if (key_replies.size() == 0) begin
          $display("%0t ns  unexpected response: expected none, actual %h", $time, rsp);
          errors++;
        end else begin
          want = key_replies.pop_front();
          match_field("event_valid", 8'(want.event_valid), 8'(rsp.event_valid));
          match_field("event_scancode", 8'(want.event_scancode), 8'(rsp.event_scancode));
          match_field("event_char", 8'(want.event_char), 8'(rsp.event_char));
          match_field("event_modifiers", 8'(want.event_modifiers),
                      8'(rsp.event_modifiers));
          match_field("live_modifiers", 8'(want.live_modifiers), 8'(rsp.live_modifiers));
          match_field("dropped", 8'(want.dropped), 8'(rsp.dropped));
        end
      end
      if (req_valid && !req_stall) begin
        reqs_accepted <= reqs_accepted + 1;
        key_replies.push_back(decode_key_request(req));
      end
    end
  end

  // Watchdog: end the run if no handshake completes for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t ns  no request or response taken for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int         total;
    int         bursts;
    int         kind;
    int         goal;
    logic [6:0] key;
    logic [6:0] shift_code;
    bit         use_shift;
    bit         use_ctrl;
    bit         use_alt;

    bursts = 0;

    // Directed: empty poll, code 0, prefix, release of code 127, shift and
    // caps alone and together, right shift, ctrl/alt, keys past the tables.
    add_item(ACT_POLL, 8'hFF);
    add_item(ACT_BYTE, 8'h00);  add_item(ACT_BYTE, PREFIX_BYTE);
    add_item(ACT_BYTE, 8'hFF);  add_item(ACT_BYTE, 8'h80);
    add_item(ACT_BYTE, 8'h1E);
    drain_next = 1'b1;
    add_item(ACT_BYTE, {1'b0, CODE_LSHIFT});
    add_item(ACT_BYTE, 8'h1E);  add_item(ACT_BYTE, 8'h10);
    add_item(ACT_BYTE, {1'b0, CODE_CAPS});  add_item(ACT_BYTE, {1'b1, CODE_CAPS});
    add_item(ACT_BYTE, 8'h1E);  add_item(ACT_BYTE, {1'b1, CODE_LSHIFT});
    add_item(ACT_BYTE, 8'h1E);  add_item(ACT_BYTE, 8'h02);
    add_item(ACT_BYTE, {1'b0, CODE_RSHIFT});  add_item(ACT_BYTE, 8'h0C);
    add_item(ACT_BYTE, {1'b1, CODE_RSHIFT});
    add_item(ACT_BYTE, {1'b0, CODE_CTRL});    add_item(ACT_BYTE, {1'b0, CODE_ALT});
    add_item(ACT_BYTE, 8'h2C);  add_item(ACT_BYTE, {1'b1, CODE_CTRL});
    add_item(ACT_BYTE, {1'b1, CODE_ALT});     add_item(ACT_BYTE, {1'b0, CODE_CAPS});
    add_item(ACT_BYTE, 8'h7F);  add_item(ACT_BYTE, 8'h57);  add_item(ACT_BYTE, 8'h53);

    // Random: mostly typing sequences with random keys and modifiers, plus
    // noise, runs of polls and a couple of bursts that overfill the ring.
    goal = keystroke_queue.size() + RANDOM_ITEMS;
    while (keystroke_queue.size() < goal) begin
      kind = $urandom_range(0, 19);
      if (bursts == 0 && keystroke_queue.size() > 500) kind = 16;
      if ($urandom_range(0, 9) == 0) drain_next = 1'b1;
      if (kind < 13) begin
        use_shift  = ($urandom_range(0, 2) == 0);
        use_ctrl   = ($urandom_range(0, 5) == 0);
        use_alt    = ($urandom_range(0, 5) == 0);
        shift_code = $urandom_range(0, 1) ? CODE_LSHIFT : CODE_RSHIFT;
        if (use_shift) add_item(ACT_BYTE, {1'b0, shift_code});
        if (use_ctrl)  add_item(ACT_BYTE, {1'b0, CODE_CTRL});
        if (use_alt)   add_item(ACT_BYTE, {1'b0, CODE_ALT});
        if ($urandom_range(0, 6) == 0) begin
          add_item(ACT_BYTE, {1'b0, CODE_CAPS});
          add_item(ACT_BYTE, {1'b1, CODE_CAPS});
        end
        repeat ($urandom_range(1, 6)) begin
          key = pick_key();
          if ($urandom_range(0, 7) == 0) add_item(ACT_BYTE, PREFIX_BYTE);
          add_item(ACT_BYTE, {1'b0, key});
          if ($urandom_range(0, 3) == 0) add_item(ACT_BYTE, {1'b0, key});
          if ($urandom_range(0, 7) == 0) add_item(ACT_BYTE, PREFIX_BYTE);
          add_item(ACT_BYTE, {1'b1, key});
          if ($urandom_range(0, 1)) add_item(ACT_POLL, 8'($urandom_range(0, 255)));
        end
        // occasionally leave a modifier held into the next sequence
        if (use_shift && $urandom_range(0, 7) != 0) add_item(ACT_BYTE, {1'b1, shift_code});
        if (use_ctrl  && $urandom_range(0, 7) != 0) add_item(ACT_BYTE, {1'b1, CODE_CTRL});
        if (use_alt   && $urandom_range(0, 7) != 0) add_item(ACT_BYTE, {1'b1, CODE_ALT});
        repeat ($urandom_range(0, 3)) add_item(ACT_POLL, 8'($urandom_range(0, 255)));
      end else if (kind < 16) begin
        repeat ($urandom_range(1, 8))
          add_item(logic'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else if (kind == 16 && bursts < 2) begin
        bursts++;
        repeat (RING_DEPTH + 8) add_item(ACT_BYTE, {1'b0, pick_key()});
        repeat (RING_DEPTH + 4) add_item(ACT_POLL, 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 6)) add_item(ACT_POLL, 8'($urandom_range(0, 255)));
      end
    end
    total = keystroke_queue.size();

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Wait for every request to be taken and every response to come back,
    // then let the pipeline settle so a stray extra response gets caught.
    while (reqs_accepted != total || key_replies.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/sck_pkg.sv
src/sck_decode.sv
src/sck_ring.sv
src/scancode_to_key_event_fifo.sv
bench/tb_scancode_to_key_event_fifo.sv
